[rtl/core/pbrp_pkg.sv]
// Shared types and constants for the PE base relocation parser.
`default_nettype none
package pbrp_pkg;

	localparam int unsigned HW_W = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned TYPE_W = 4;
	localparam int unsigned ENTRIES_W = 31;

	localparam logic [TYPE_W-1:0] TYPE_HIGHLOW = 4'd3;
	localparam logic [WORD_W-1:0] HEADER_BYTES = 32'd8;

	localparam logic KIND_PATCH = 1'b0;
	localparam logic KIND_MALFORMED = 1'b1;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_RELOC_DELTA = 3'd0;

	typedef struct packed {
		logic valid;
		logic last;
		logic [HW_W-1:0] half_word;
	} pbrp_beat_t;

	typedef struct packed {
		logic kind;
		logic [WORD_W-1:0] patch_rva;
		logic [WORD_W-1:0] add_value;
	} pbrp_result_t;

endpackage
`default_nettype wire

[rtl/core/pbrp_parse.sv]
// Block header and entry walker of the relocation parser.
`default_nettype none
module pbrp_parse
	import pbrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pbrp_beat_t beat,
	input  wire logic [WORD_W-1:0] reloc_delta,
	output logic res_valid,
	output pbrp_result_t res
);

	typedef enum logic [2:0] {
		PH_RVA_LO  = 3'd0,
		PH_RVA_HI  = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_ENTRY   = 3'd4,
		PH_HALT    = 3'd5
	} phase_t;

	phase_t phase_q;
	logic [WORD_W-1:0] page_rva_q;
	logic [HW_W-1:0] size_lo_q;
	logic [ENTRIES_W-1:0] entries_q;

	logic [WORD_W-1:0] size;
	logic [WORD_W-1:0] size_m8;
	logic malformed;
	logic delta_nz;
	logic [ENTRIES_W-1:0] entries_dec;

	assign size = {beat.half_word, size_lo_q};
	assign size_m8 = size - HEADER_BYTES;
	assign malformed = (size < HEADER_BYTES) || size[0];
	assign delta_nz = (reloc_delta != '0);
	assign entries_dec = entries_q - ENTRIES_W'(1);

	always_comb begin
		res_valid = 1'b0;
		res.kind = KIND_PATCH;
		res.patch_rva = '0;
		res.add_value = '0;
		if (beat.valid && delta_nz) begin
			unique case (phase_q)
				PH_SIZE_HI: begin
					if (malformed) begin
						res_valid = 1'b1;
						res.kind = KIND_MALFORMED;
					end
				end
				PH_ENTRY: begin
					if (beat.half_word[HW_W-1 -: TYPE_W] == TYPE_HIGHLOW) begin
						res_valid = 1'b1;
						res.patch_rva = page_rva_q
							+ WORD_W'(beat.half_word[OFFSET_W-1:0]);
						res.add_value = reloc_delta;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RVA_LO;
			page_rva_q <= '0;
			size_lo_q <= '0;
			entries_q <= '0;
		end else if (beat.valid) begin
			if (beat.last) begin
				phase_q <= PH_RVA_LO;
				page_rva_q <= '0;
				size_lo_q <= '0;
				entries_q <= '0;
			end else begin
				unique case (phase_q)
					PH_RVA_LO: begin
						page_rva_q <= {{(WORD_W-HW_W){1'b0}}, beat.half_word};
						phase_q <= PH_RVA_HI;
					end
					PH_RVA_HI: begin
						page_rva_q <= {beat.half_word, page_rva_q[HW_W-1:0]};
						phase_q <= PH_SIZE_LO;
					end
					PH_SIZE_LO: begin
						size_lo_q <= beat.half_word;
						phase_q <= PH_SIZE_HI;
					end
					PH_SIZE_HI: begin
						if (malformed) begin
							phase_q <= PH_HALT;
						end else begin
							entries_q <= size_m8[WORD_W-1:1];
							phase_q <= (size_m8[WORD_W-1:1] != '0) ? PH_ENTRY : PH_RVA_LO;
						end
					end
					PH_ENTRY: begin
						entries_q <= entries_dec;
						if (entries_dec == '0) begin
							phase_q <= PH_RVA_LO;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/pe_base_reloc_parser_top.sv]
// Top level of the PE base relocation parser with stream and register ports.
//
//   Channel  Direction  Beat contents
//   s_*      in         tdata[15:0] half_word, tlast last_of_directory
//   m_*      out        tdata[31:0] patch_rva, tdata[63:32] add_value, tuser kind
//   APB      in/out     reloc_delta at byte address 0
//
// One halfword enters every cycle unless m_tready stalls; each result is registered at the output.
// The input register and the output register are the only pipeline stages.
// Reset clears the parser to expect a block page RVA and clears reloc_delta.
// While a result beat waits on m_tready, s_tready is low whenever the input register is full.
`default_nettype none
module pe_base_reloc_parser_top
	import pbrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [15:0] s_tdata, // half_word
	input  wire logic s_tlast,
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [63:0] m_tdata, // patch_rva, add_value
	output logic m_tuser, // kind
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [WORD_W-1:0] reloc_delta_q;
	logic valid_s1;
	logic last_s1;
	logic [HW_W-1:0] hw_s1;
	logic advance;
	pbrp_beat_t beat;
	logic res_valid;
	pbrp_result_t res;
	logic m_tvalid_q;
	pbrp_result_t res_q;
	logic reg_hit;

	assign pready = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == ADDR_RELOC_DELTA[PADDR_W-1:2]);
	assign prdata = reg_hit ? reloc_delta_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reloc_delta_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			reloc_delta_q <= pwdata;
		end
	end

	assign advance = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hw_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign beat.valid = valid_s1 && advance;
	assign beat.last = last_s1;
	assign beat.half_word = hw_s1;

	pbrp_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.beat(beat),
		.reloc_delta(reloc_delta_q),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {res_q.add_value, res_q.patch_rva};
	assign m_tuser = res_q.kind;

endmodule
`default_nettype wire

[rtl/core/pbrp_checker.sv]
// Port-level checks for the relocation parser and their binding to the top level.
`default_nettype none
module pbrp_checker
	import pbrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tready,
	input  wire logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic [63:0] m_tdata,
	input  wire logic m_tuser,
	input  wire logic pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Output beat changed while stalled.");

	a_malformed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MALFORMED) |-> m_tdata == '0)
		else $error("Malformed report carries a nonzero payload.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("Input stalled without a pending output beat.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> pready)
		else $error("Register port was not ready.");

endmodule

bind pe_base_reloc_parser_top pbrp_checker u_pbrp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.pready(pready)
);
`default_nettype wire
